// ===== design/sm4_block_encrypt_top_assert.svh =====
// assertion macros for the sm4 block encrypt engine
`ifndef SM4_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`ifndef SYNTH
`define SM4_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SM4_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SM4_ASSERT_IMP(label, clk, rst_n, a, c)
`define SM4_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4_pkg
// shared types, s-box and round function for the sm4 engine
// ----------------------------------------------------------------------------
`default_nettype none
package sm4_pkg;
  localparam int WORD_W = 32;
  localparam int KIDX_W = 5;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ENC  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  we;
    logic  [KIDX_W-1:0] waddr;
    word_t wdata;
    logic  re;
    logic  [KIDX_W-1:0] raddr;
  } key_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t sm4_mix(input word_t x);
    word_t b;
    b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction
endpackage
`default_nettype wire

// ===== design/sm4_block_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// sm4_block_encrypt_top
// sm4 encryption engine with an on-chip round key store
// ----------------------------------------------------------------------------
// in_ channel: one transaction is a key load (in_kind low) or a block
// encrypt (in_kind high). a load writes in_key_word to key slot
// in_key_index at the accepting edge and gives no result. all 32 keys must be
// loaded before the first encrypt.
// an encrypt runs one round per cycle from the key store, whose read
// port is registered: the first key is fetched at the accepting edge,
// then the 32 rounds run in ST_RUN and ST_DONE loads the output
// register once it is free; a new block is accepted only after the
// previous one has left ST_DONE and the engine is idle again.
// out_ channel: result held in the output register until taken; while
// out_stall is high the next block may run but waits to unload.
// reset: rst_n synchronous active low clears control; key store is not
// cleared and its contents survive reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sm4_block_encrypt_top_assert.svh"
module sm4_block_encrypt_top
  import sm4_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [4:0]  in_key_index,
  input  wire  [31:0] in_key_word,
  input  wire  [31:0] in_word0,
  input  wire  [31:0] in_word1,
  input  wire  [31:0] in_word2,
  input  wire  [31:0] in_word3,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out0,
  output logic [31:0] out1,
  output logic [31:0] out2,
  output logic [31:0] out3
);
  localparam int RND_W = $clog2(ROUNDS);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_RUN, ST_DONE} state_t;

  state_t           state_r;
  logic [RND_W-1:0] rnd_r;
  word_t            w0_r, w1_r, w2_r, w3_r;
  logic             out_valid_r;
  word_t            o0_r, o1_r, o2_r, o3_r;
  word_t            rkey;
  word_t            nw;
  key_ctl_t         kctl;
  logic             acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    kctl.we    = acc && (in_kind == KIND_LOAD);
    kctl.waddr = in_key_index;
    kctl.wdata = in_key_word;
    kctl.re    = 1'b0;
    kctl.raddr = rnd_r;
    if (acc && in_kind == KIND_ENC) begin
      kctl.re    = 1'b1;
      kctl.raddr = '0;
    end else if (state_r == ST_FETCH || state_r == ST_RUN) begin
      kctl.re    = 1'b1;
      kctl.raddr = rnd_r + RND_W'(1);
    end
  end

  sm4_key_ram #(.DEPTH(ROUNDS)) u_keys (
    .clk   (clk),
    .ctl   (kctl),
    .rdata (rkey)
  );

  assign nw = w0_r ^ sm4_mix(w1_r ^ w2_r ^ w3_r ^ rkey);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc && in_kind == KIND_ENC) begin
            w0_r    <= in_word0;
            w1_r    <= in_word1;
            w2_r    <= in_word2;
            w3_r    <= in_word3;
            rnd_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          w0_r  <= w1_r;
          w1_r  <= w2_r;
          w2_r  <= w3_r;
          w3_r  <= nw;
          rnd_r <= rnd_r + RND_W'(1);
          if (rnd_r == RND_W'(ROUNDS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            o0_r        <= w3_r;
            o1_r        <= w2_r;
            o2_r        <= w1_r;
            o3_r        <= w0_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out0 = o0_r;
  assign out1 = o1_r;
  assign out2 = o2_r;
  assign out3 = o3_r;

  `SM4_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
  `SM4_ASSERT_NXT(a_enc_starts, clk, rst_n, acc && in_kind == KIND_ENC, state_r == ST_RUN)
  `SM4_ASSERT_NXT(a_done_loads, clk, rst_n,
    state_r == ST_DONE && (!out_valid_r || !out_stall), out_valid_r && state_r == ST_IDLE)
  `SM4_ASSERT_IMP(a_run_reads, clk, rst_n, state_r == ST_RUN, kctl.re && !kctl.we)
endmodule
`default_nettype wire

// ===== design/sm4_key_ram.sv =====
// ----------------------------------------------------------------------------
// sm4_key_ram
// round key store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_key_ram
  import sm4_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire      clk,
  input  key_ctl_t ctl,
  output word_t    rdata
);
  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[ctl.raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// sm4 block encrypt testbench
// loads round keys, encrypts directed and random blocks under random idling
// on both channels and checks each ciphertext against an in-bench sm4 model
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import sm4_pkg::*;

  typedef struct {
    logic        kind;
    logic [4:0]  kidx;
    logic [31:0] kword;
    logic [31:0] w0, w1, w2, w3;
    logic        has_exp;
    logic [31:0] e0, e1, e2, e3;
  } stim_row_t;

  typedef struct {
    logic [31:0] c0, c1, c2, c3;
  } cipher_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire  in_stall;
  logic in_kind = 1'b0;
  logic [4:0] in_key_index = '0;
  logic [31:0] in_key_word = '0;
  logic [31:0] in_word0 = '0, in_word1 = '0, in_word2 = '0, in_word3 = '0;
  wire  out_valid;
  logic out_stall = 1'b0;
  wire  [31:0] out0, out1, out2, out3;

  always #1 clk = ~clk;

  sm4_block_encrypt_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_key_index(in_key_index), .in_key_word(in_key_word),
    .in_word0(in_word0), .in_word1(in_word1), .in_word2(in_word2), .in_word3(in_word3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out0(out0), .out1(out1), .out2(out2), .out3(out3)
  );

  logic [31:0] key_shadow [32];
  cipher_t     cipher_q[$];
  int          errors = 0;
  int          blocks_done = 0;
  int          loads_done = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;

  localparam int WATCHDOG = 20000;

  logic [7:0] sb [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau_l(input logic [31:0] x);
    logic [31:0] b;
    b = {sb[x[31:24]], sb[x[23:16]], sb[x[15:8]], sb[x[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  function automatic cipher_t encrypt_block(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
    logic [31:0] x [4];
    logic [31:0] nx;
    cipher_t r;
    x[0] = a; x[1] = b; x[2] = c; x[3] = d;
    for (int i = 0; i < 32; i++) begin
      nx = x[0] ^ tau_l(x[1] ^ x[2] ^ x[3] ^ key_shadow[i]);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    r.c0 = x[3]; r.c1 = x[2]; r.c2 = x[1]; r.c3 = x[0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // drive one transaction and wait until it is accepted
  task automatic send_item(input stim_row_t s);
    cipher_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_key_index <= s.kidx;
    in_key_word <= s.kword;
    in_word0 <= s.w0; in_word1 <= s.w1; in_word2 <= s.w2; in_word3 <= s.w3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s.kind == KIND_LOAD) begin
      key_shadow[s.kidx] = s.kword;
      loads_done++;
    end else begin
      c = encrypt_block(s.w0, s.w1, s.w2, s.w3);
      if (s.has_exp) begin
        c.c0 = s.e0; c.c1 = s.e1; c.c2 = s.e2; c.c3 = s.e3;
      end
      cipher_q.push_back(c);
    end
  endtask

  function automatic stim_row_t load_row(input int idx, input logic [31:0] v);
    stim_row_t s;
    s = '{default: '0};
    s.kind = KIND_LOAD; s.kidx = idx[4:0]; s.kword = v;
    s.w0 = $urandom; s.w1 = $urandom; s.w2 = $urandom; s.w3 = $urandom;
    return s;
  endfunction

  function automatic stim_row_t enc_row(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    stim_row_t s;
    s = '{default: '0};
    s.kind = KIND_ENC; s.kidx = 5'($urandom); s.kword = $urandom;
    s.w0 = a; s.w1 = b; s.w2 = c; s.w3 = d;
    return s;
  endfunction

  // receiver side
  always @(posedge clk) begin
    cipher_t c;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result out0", out0, '0);
      end else begin
        c = cipher_q.pop_front();
        if (out0 !== c.c0) report_mismatch("out0", out0, c.c0);
        if (out1 !== c.c1) report_mismatch("out1", out1, c.c1);
        if (out2 !== c.c2) report_mismatch("out2", out2, c.c2);
        if (out3 !== c.c3) report_mismatch("out3", out3, c.c3);
        blocks_done++;
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results pending", cipher_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering blocks
  task automatic hold_receiver(input int n);
    hold_off = 1'b1;
    repeat (n) @(posedge clk);
    hold_off = 1'b0;
  endtask

  stim_row_t table_rows[$];

  initial begin
    stim_row_t s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero keys with zero, all-ones and standard plaintext blocks, then all-ones keys
    for (int i = 0; i < 32; i++) table_rows.push_back(load_row(i, 32'h0));
    table_rows.push_back(enc_row('0, '0, '0, '0));
    table_rows.push_back(enc_row('1, '1, '1, '1));
    table_rows.push_back(enc_row(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210));
    for (int i = 31; i >= 0; i--) table_rows.push_back(load_row(i, '1));
    table_rows.push_back(enc_row('0, '0, '0, '0));
    table_rows.push_back(enc_row('1, '0, '1, '0));
    table_rows.push_back(enc_row(32'h80000000, 32'h00000001, 32'h7fffffff, 32'hfffffffe));
    foreach (table_rows[i]) send_item(table_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 20 : 0;
      if (ph == 2) fork hold_receiver(400); join_none
      for (int k = 0; k < 230; k++) begin
        if ($urandom_range(99) < 20)
          s = load_row($urandom_range(31), $urandom);
        else
          s = enc_row($urandom, $urandom, $urandom, $urandom);
        send_item(s);
      end
    end
    in_valid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d key loads and %0d checked blocks under mixed idling",
             loads_done, blocks_done);
    if (errors == 0 && cipher_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
